// ----- rtl/core/mow_pkg.sv -----
// Package for the median-of-window core: value and window types, the
// odd-even merge sorting network description and the compare-exchange layer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mow_pkg;

   localparam int WINDOW_SLOTS = 8;
   localparam int VALUE_BITS   = 48;
   localparam int COUNT_BITS   = 4;
   localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);

   // Batcher odd-even merge network for eight slots: six layers, up to four
   // compare-exchanges each. A pair of equal indices is a no-op filler.
   localparam int SORT_LAYERS   = 6;
   localparam int LAYER_CMPS    = 4;
   localparam int LAYER_BITS    = $clog2(SORT_LAYERS);
   localparam int SORT_STAGES   = 3;
   localparam int LAYERS_PER_STAGE = SORT_LAYERS / SORT_STAGES;

   typedef logic [VALUE_BITS-1:0]            value_type;
   typedef value_type [WINDOW_SLOTS-1:0]     window_type;
   typedef logic [COUNT_BITS-1:0]            count_type;
   typedef logic [SLOT_BITS-1:0]             slot_index_type;
   typedef logic [LAYER_BITS-1:0]            layer_index_type;

   localparam slot_index_type CMP_LO [SORT_LAYERS][LAYER_CMPS] = '{
      '{3'd0, 3'd2, 3'd4, 3'd6},
      '{3'd0, 3'd1, 3'd4, 3'd5},
      '{3'd1, 3'd5, 3'd0, 3'd0},
      '{3'd0, 3'd1, 3'd2, 3'd3},
      '{3'd2, 3'd3, 3'd0, 3'd0},
      '{3'd1, 3'd3, 3'd5, 3'd0}
   };

   localparam slot_index_type CMP_HI [SORT_LAYERS][LAYER_CMPS] = '{
      '{3'd1, 3'd3, 3'd5, 3'd7},
      '{3'd2, 3'd3, 3'd6, 3'd7},
      '{3'd2, 3'd6, 3'd0, 3'd0},
      '{3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd4, 3'd5, 3'd0, 3'd0},
      '{3'd2, 3'd4, 3'd6, 3'd0}
   };

   // One layer of the network; the pairs in a layer are disjoint.
   function automatic window_type compare_layer(window_type w, layer_index_type layer);
      window_type     r;
      value_type      a;
      value_type      b;
      slot_index_type lo;
      slot_index_type hi;
      r = w;
      for (int k = 0; k < LAYER_CMPS; k++) begin
         lo = CMP_LO[layer][k];
         hi = CMP_HI[layer][k];
         a  = r[lo];
         b  = r[hi];
         if (a > b) begin
            r[lo] = b;
            r[hi] = a;
         end
      end
      return r;
   endfunction

   // floor((a + b) / 2) without losing the carry
   function automatic value_type half_sum(value_type a, value_type b);
      logic [VALUE_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[VALUE_BITS:1];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mow_channels.sv -----
// Valid/ready channel interfaces for the median-of-window core: the window
// request channel and the median response channel. Depends on mow_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mow_req_if
   import mow_pkg::*;
   ;
   logic      valid;
   logic      ready;
   count_type valid_count;
   value_type value_0;
   value_type value_1;
   value_type value_2;
   value_type value_3;
   value_type value_4;
   value_type value_5;
   value_type value_6;
   value_type value_7;

   modport source (
      output valid, valid_count, value_0, value_1, value_2, value_3,
             value_4, value_5, value_6, value_7,
      input  ready
   );
   modport sink (
      input  valid, valid_count, value_0, value_1, value_2, value_3,
             value_4, value_5, value_6, value_7,
      output ready
   );
endinterface

interface mow_rsp_if
   import mow_pkg::*;
   ;
   logic      valid;
   logic      ready;
   value_type median_value;

   modport source (output valid, median_value, input ready);
   modport sink   (input valid, median_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/median_of_window_core.sv -----
// Median of a window of up to eight unsigned 32.16 values.
//
// Channels: req_chan carries valid_count and value_0..value_7; slots at or
// beyond the count are ignored and a count above eight means all eight.
// rsp_chan returns median_value: the middle value for an odd count, the
// truncated mean of the two middle values for an even count, zero for an
// empty window. Every request beat yields exactly one response beat, in order.
//
// Path: a request passes the input register, three sorting-network stages
// and the output register, whose median select and half-sum follow the
// last stage.
// Throughput: one window per cycle unless rsp_chan stalls; each of the
// three network stages holds two of the six compare-exchange layers.
//
// Reset (synchronous, active high) empties every stage; nothing else is
// held. When the receiver stalls, each stage holds its beat and only stages
// behind a full stage stop, so bubbles fill before req_chan.ready drops.
// Depends on mow_pkg, mow_channels and mow_sorter.
`timescale 1ns / 1ps
`default_nettype none

module median_of_window_core
   import mow_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   mow_req_if.sink   req_chan,
   mow_rsp_if.source rsp_chan
);

   // input register
   logic       in_valid_ff;
   window_type in_window_ff;
   count_type  in_count_ff;
   window_type in_window_in;
   count_type  in_count_in;
   window_type raw_window;
   logic       in_ready;

   logic       sort_in_ready;
   logic       sort_valid;
   logic       sort_ready;
   window_type sort_window;
   count_type  sort_count;

   // output register
   logic       out_valid_ff;
   value_type  median_ff;
   value_type  median_in;
   count_type  n_minus_one;
   slot_index_type lo_idx;
   slot_index_type hi_idx;

   assign raw_window = {req_chan.value_7, req_chan.value_6, req_chan.value_5,
                        req_chan.value_4, req_chan.value_3, req_chan.value_2,
                        req_chan.value_1, req_chan.value_0};

   // Unused slots become all ones so they sort past every valid value.
   always_comb begin
      if (req_chan.valid_count > COUNT_BITS'(WINDOW_SLOTS)) begin
         in_count_in = COUNT_BITS'(WINDOW_SLOTS);
      end else begin
         in_count_in = req_chan.valid_count;
      end
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         if (COUNT_BITS'(i) < in_count_in) begin
            in_window_in[i] = raw_window[i];
         end else begin
            in_window_in[i] = '1;
         end
      end
   end

   assign in_ready       = !in_valid_ff || sort_in_ready;
   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_window_ff <= in_window_in;
         in_count_ff  <= in_count_in;
      end
   end

   mow_sorter u_sorter (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_ready   (sort_in_ready),
      .in_window  (in_window_ff),
      .in_count   (in_count_ff),
      .out_valid  (sort_valid),
      .out_ready  (sort_ready),
      .out_window (sort_window),
      .out_count  (sort_count)
   );

   // Middle pair: (n-1)/2 and n/2; the same slot for an odd count, and
   // half_sum of a value with itself gives the value back.
   assign n_minus_one = sort_count - COUNT_BITS'(1);
   assign lo_idx      = n_minus_one[SLOT_BITS:1];
   assign hi_idx      = sort_count[SLOT_BITS:1];

   always_comb begin
      if (sort_count == '0) begin
         median_in = '0;
      end else begin
         median_in = half_sum(sort_window[lo_idx], sort_window[hi_idx]);
      end
   end

   assign sort_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (sort_ready) begin
         out_valid_ff <= sort_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sort_ready && sort_valid) begin
         median_ff <= median_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.median_value = median_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mow_sorter.sv -----
// Three-stage pipelined sorting network, two compare layers per stage.
// The window count rides along with each beat. Depends on mow_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mow_sorter
   import mow_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output      logic       in_ready,
   input  wire window_type in_window,
   input  wire count_type  in_count,
   output      logic       out_valid,
   input  wire logic       out_ready,
   output      window_type out_window,
   output      count_type  out_count
);

   logic       valid_ff  [SORT_STAGES];
   window_type window_ff [SORT_STAGES];
   count_type  count_ff  [SORT_STAGES];

   logic       stage_ready [SORT_STAGES];
   logic       prev_valid  [SORT_STAGES];
   window_type prev_window [SORT_STAGES];
   count_type  prev_count  [SORT_STAGES];
   window_type window_in   [SORT_STAGES];

   for (genvar s = 0; s < SORT_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign prev_valid[s]  = in_valid;
         assign prev_window[s] = in_window;
         assign prev_count[s]  = in_count;
      end else begin : g_next
         assign prev_valid[s]  = valid_ff[s-1];
         assign prev_window[s] = window_ff[s-1];
         assign prev_count[s]  = count_ff[s-1];
      end

      if (s == SORT_STAGES - 1) begin : g_last_rdy
         assign stage_ready[s] = !valid_ff[s] || out_ready;
      end else begin : g_mid_rdy
         assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end

      always_comb begin
         window_in[s] = prev_window[s];
         for (int l = 0; l < LAYERS_PER_STAGE; l++) begin
            window_in[s] = compare_layer(window_in[s],
                              LAYER_BITS'(s * LAYERS_PER_STAGE + l));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= prev_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s] && prev_valid[s]) begin
            window_ff[s] <= window_in[s];
            count_ff[s]  <= prev_count[s];
         end
      end
   end

   assign in_ready   = stage_ready[0];
   assign out_valid  = valid_ff[SORT_STAGES-1];
   assign out_window = window_ff[SORT_STAGES-1];
   assign out_count  = count_ff[SORT_STAGES-1];

endmodule

`default_nettype wire
